// ===== sv/ptd_pkg.sv =====
`default_nettype none
package ptd_pkg;

	localparam int TASK_SLOTS = 8;
	localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

	// func codes
	localparam logic [2:0] FN_CREATE  = 3'd0;
	localparam logic [2:0] FN_SUSPEND = 3'd1;
	localparam logic [2:0] FN_RESUME  = 3'd2;
	localparam logic [2:0] FN_DELETE  = 3'd3;
	localparam logic [2:0] FN_TICK    = 3'd4;

	// result kinds
	localparam logic [3:0] K_CREATED       = 4'd0;
	localparam logic [3:0] K_SUSPENDED     = 4'd1;
	localparam logic [3:0] K_RESUMED       = 4'd2;
	localparam logic [3:0] K_DELETED       = 4'd3;
	localparam logic [3:0] K_BUSY          = 4'd4;
	localparam logic [3:0] K_NOT_RUNNING   = 4'd5;
	localparam logic [3:0] K_NOT_SUSPENDED = 4'd6;
	localparam logic [3:0] K_RANGE         = 4'd7;
	localparam logic [3:0] K_DISPATCH      = 4'd8;
	localparam logic [3:0] K_TICK_DONE     = 4'd9;

	typedef enum logic [1:0] {
		ST_DORMANT   = 2'd0,
		ST_RUNNING   = 2'd1,
		ST_SUSPENDED = 2'd2
	} slot_state_t;

	typedef enum logic [1:0] {
		SQ_IDLE = 2'd0,
		SQ_WALK = 2'd1,
		SQ_DONE = 2'd2
	} seq_state_t;

	typedef struct packed {
		logic [2:0]  func;
		logic [7:0]  slot;
		logic [7:0]  task_tag;
		logic [31:0] period;
	} cmd_word_t;

	typedef struct packed {
		logic [3:0] kind;
		logic [5:0] task_slot;
		logic [7:0] tag_out;
		logic       last;
	} res_word_t;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		logic        start;
		logic        adv;
		logic        wr;
		slot_state_t new_state;
		logic        load;
		logic [7:0]  tag;
		logic [31:0] period;
	} cell_ctrl_t;

	// status of one cell back to the sequencer
	typedef struct packed {
		slot_state_t state;
		logic        tok;
		logic        hit;
		logic [7:0]  tag;
	} cell_stat_t;

endpackage
`default_nettype wire

// ===== sv/periodic_task_dispatcher_top.sv =====
// Command (create/suspend/resume/delete): one status word, registered in the cycle after accept.
// Tick: a visit token walks the row of slot cells, one cell per cycle unless a due slot waits
// on a stalled result; no new word is taken until the tick is done.
// Commands and unused codes leave the sequencer idle.
// Reset: all slots dormant, all tick counts zero, no result pending.
`default_nettype none
module periodic_task_dispatcher_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire ptd_pkg::cmd_word_t cmd,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output ptd_pkg::res_word_t      res
);

	localparam int N = ptd_pkg::TASK_SLOTS;

	ptd_pkg::seq_state_t state_q, state_nxt;
	ptd_pkg::cell_ctrl_t ctrl;
	ptd_pkg::cell_stat_t cell_st [N];
	ptd_pkg::res_word_t  res_q, res_nxt;
	ptd_pkg::slot_state_t cur_state;
	logic [N-1:0]        sel;
	logic                res_valid_q;
	logic                res_load;
	logic                res_free;
	logic                acc;
	logic                in_range;
	logic                hit_any;
	logic [5:0]          disp_slot;
	logic [7:0]          disp_tag;

	assign res_free  = !res_valid_q || !res_stall;
	assign cmd_stall = (state_q != ptd_pkg::SQ_IDLE) || (res_valid_q && res_stall);
	assign acc       = cmd_valid && !cmd_stall;
	assign in_range  = (cmd.slot < 8'(N));
	assign cur_state = cell_st[cmd.slot[ptd_pkg::SLOT_W-1:0]].state;

	for (genvar i = 0; i < N; i++) begin : g_cell
		assign sel[i] = in_range && (cmd.slot == 8'(i));
		ptd_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctrl  (ctrl),
			.sel   (sel[i]),
			.tok_in((i == 0) ? ctrl.start : cell_st[(i == 0) ? 0 : i-1].tok),
			.stat  (cell_st[i])
		);
	end

	// one token in the row, so OR-ing is a select
	always_comb begin
		hit_any   = 1'b0;
		disp_slot = '0;
		disp_tag  = '0;
		for (int i = 0; i < N; i++) begin
			if (cell_st[i].tok) begin
				hit_any   = hit_any | cell_st[i].hit;
				disp_slot = disp_slot | 6'(i);
				disp_tag  = disp_tag | cell_st[i].tag;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ptd_pkg::SQ_IDLE: begin
				if (acc && (cmd.func == ptd_pkg::FN_TICK)) begin
					state_nxt = ptd_pkg::SQ_WALK;
				end
			end
			ptd_pkg::SQ_WALK: begin
				if (cell_st[N-1].tok && ctrl.adv) begin
					state_nxt = ptd_pkg::SQ_DONE;
				end
			end
			ptd_pkg::SQ_DONE: begin
				if (res_free) begin
					state_nxt = ptd_pkg::SQ_IDLE;
				end
			end
			default: state_nxt = ptd_pkg::SQ_IDLE;
		endcase
	end

	always_comb begin
		ctrl           = '0;
		ctrl.new_state = ptd_pkg::ST_DORMANT;
		ctrl.tag       = cmd.task_tag;
		ctrl.period    = cmd.period;
		res_load       = 1'b0;
		res_nxt        = '0;
		case (state_q)
			ptd_pkg::SQ_IDLE: begin
				if (acc) begin
					res_nxt.task_slot = cmd.slot[5:0];
					res_nxt.last      = 1'b1;
					case (cmd.func)
						ptd_pkg::FN_TICK: begin
							ctrl.start = 1'b1;
						end
						ptd_pkg::FN_CREATE: begin
							res_load = 1'b1;
							if (cur_state == ptd_pkg::ST_DORMANT) begin
								ctrl.wr        = in_range;
								ctrl.load      = 1'b1;
								ctrl.new_state = ptd_pkg::ST_RUNNING;
								res_nxt.kind   = ptd_pkg::K_CREATED;
							end else begin
								res_nxt.kind = ptd_pkg::K_BUSY;
							end
						end
						ptd_pkg::FN_SUSPEND: begin
							res_load = 1'b1;
							if (cur_state == ptd_pkg::ST_RUNNING) begin
								ctrl.wr        = in_range;
								ctrl.new_state = ptd_pkg::ST_SUSPENDED;
								res_nxt.kind   = ptd_pkg::K_SUSPENDED;
							end else begin
								res_nxt.kind = ptd_pkg::K_NOT_RUNNING;
							end
						end
						ptd_pkg::FN_RESUME: begin
							res_load = 1'b1;
							if (cur_state == ptd_pkg::ST_SUSPENDED) begin
								ctrl.wr        = in_range;
								ctrl.new_state = ptd_pkg::ST_RUNNING;
								res_nxt.kind   = ptd_pkg::K_RESUMED;
							end else begin
								res_nxt.kind = ptd_pkg::K_NOT_SUSPENDED;
							end
						end
						ptd_pkg::FN_DELETE: begin
							res_load = 1'b1;
							if (cur_state != ptd_pkg::ST_DORMANT) begin
								ctrl.wr        = in_range;
								ctrl.new_state = ptd_pkg::ST_DORMANT;
								res_nxt.kind   = ptd_pkg::K_DELETED;
							end else begin
								res_nxt.kind = ptd_pkg::K_NOT_RUNNING;
							end
						end
						default: begin
							res_load = 1'b0;
						end
					endcase
					// out-of-range slot overrides any status, no state change
					if (!in_range) begin
						ctrl.wr      = 1'b0;
						res_nxt.kind = ptd_pkg::K_RANGE;
					end
				end
			end
			ptd_pkg::SQ_WALK: begin
				// hold the token on a due slot until the result register frees up
				ctrl.adv          = !hit_any || res_free;
				res_load          = hit_any && res_free;
				res_nxt.kind      = ptd_pkg::K_DISPATCH;
				res_nxt.task_slot = disp_slot;
				res_nxt.tag_out   = disp_tag;
			end
			ptd_pkg::SQ_DONE: begin
				res_load     = res_free;
				res_nxt.kind = ptd_pkg::K_TICK_DONE;
				res_nxt.last = 1'b1;
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ptd_pkg::SQ_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			res_valid_q <= res_load || (res_valid_q && res_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
`default_nettype wire

// ===== sv/ptd_cell.sv =====
`default_nettype none
module ptd_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ptd_pkg::cell_ctrl_t ctrl,
	input  wire logic              sel,
	input  wire logic              tok_in,
	output ptd_pkg::cell_stat_t    stat
);

	ptd_pkg::slot_state_t state_q;
	logic [31:0]          ticks_q;
	logic [31:0]          period_q;
	logic [7:0]           tag_q;
	logic                 tok_q;
	logic                 running;
	logic                 hit;
	logic                 visit;

	assign running = (state_q == ptd_pkg::ST_RUNNING);
	assign hit     = running && ((ticks_q == 32'd0) || (ticks_q > period_q));
	assign visit   = tok_q && ctrl.adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptd_pkg::ST_DORMANT;
			ticks_q <= '0;
			tok_q   <= 1'b0;
		end else begin
			if (ctrl.start || ctrl.adv) begin
				tok_q <= tok_in;
			end
			if (sel && ctrl.wr) begin
				state_q <= ctrl.new_state;
			end
			if (visit && running) begin
				if (hit) begin
					ticks_q <= period_q;
				end else begin
					ticks_q <= ticks_q - 32'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sel && ctrl.wr && ctrl.load) begin
			tag_q    <= ctrl.tag;
			period_q <= ctrl.period;
		end
	end

	assign stat.state = state_q;
	assign stat.tok   = tok_q;
	assign stat.hit   = hit;
	assign stat.tag   = tag_q;

endmodule
`default_nettype wire
